// File: hw/rtl/spot_pkg.sv
// Shared types and constants of the swap page owner table
package spot_pkg;

    // Table geometry
    localparam int SLOTS      = 64;
    localparam int OWNER_BITS = 8;
    localparam int PAGE_BITS  = 16;

    // Fixed field widths of the beats
    localparam int ID_W   = 8;
    localparam int PGF_W  = 16;
    localparam int RET_W  = 16;
    localparam int FREE_W = 7;

    // Stored key widths: identifiers are masked to the configured bit counts
    localparam int OWN_W = (OWNER_BITS < ID_W)  ? OWNER_BITS : ID_W;
    localparam int PG_W  = (PAGE_BITS  < PGF_W) ? PAGE_BITS  : PGF_W;

    // Slot index and scan counter widths
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;

    localparam int ENT_W = OWN_W + PG_W + RET_W;

    localparam logic [RET_W-1:0] RET_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_SAVE   = 2'd1,
        OP_LOAD   = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_FULL   = 2'd1,
        ERR_ABSENT = 2'd2
    } err_t;

    typedef struct packed {
        op_t              operation;
        logic [ID_W-1:0]  process_id;
        logic [PGF_W-1:0] page;
    } in_t;

    typedef struct packed {
        logic              found;
        logic [RET_W-1:0]  return_count;
        logic [FREE_W-1:0] free_slots;
        err_t              error;
    } out_t;

    // One slot as held in the RAM
    typedef struct packed {
        logic [OWN_W-1:0] owner;
        logic [PG_W-1:0]  page;
        logic [RET_W-1:0] returns;
    } entry_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic             clear;
        logic             live;
        logic             del;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    // Scan unit accumulators
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [RET_W-1:0]  hit_ret;
        logic              has_free;
        logic [IDX_W-1:0]  free_idx;
        logic [FREE_W-1:0] free_cnt;
    } scan_res_t;

endpackage

// File: hw/rtl/swap_page_owner_table.sv
// Channel  | Ports                      | Beat
// ---------+----------------------------+------------------------------------
// request  | s_valid, s_ready, s_data   | operation, process_id, page
// result   | m_valid, m_ready, m_data   | found, return_count, free_slots, error
//
// One operation: a scan over every slot (one slot a cycle, registered RAM read),
// an update state and an output state; the result beat is offered as the
// sequencer returns to idle and s_ready rises with it, so a new request is taken
// only once the previous result has entered the output register. The result
// waits there for m_ready; only an unread older result holds the sequencer back.
// aresetn (synchronous) frees every slot at once through the valid bits.
module swap_page_owner_table (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  spot_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output spot_pkg::out_t   m_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    spot_pkg::op_t                op_reg, op_next;
    logic [spot_pkg::OWN_W-1:0]   own_reg, own_next;
    logic [spot_pkg::PG_W-1:0]    pg_reg, pg_next;
    logic [spot_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         live_reg, live_next;
    logic [spot_pkg::IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [spot_pkg::SLOTS-1:0]   valid_reg, valid_next;
    spot_pkg::out_t               pend_reg, pend_next;
    logic                         m_valid_reg, m_valid_next;
    spot_pkg::out_t               m_data_reg, m_data_next;

    logic                         accept;
    logic                         rd_en;
    logic [spot_pkg::IDX_W-1:0]   rd_addr;
    logic [spot_pkg::ENT_W-1:0]   rd_data;
    logic                         wr_en;
    logic [spot_pkg::IDX_W-1:0]   wr_addr;
    spot_pkg::entry_t             wr_entry;
    spot_pkg::scan_ctl_t          scan_ctl;
    spot_pkg::scan_res_t          scan_res;
    logic                         kill;
    logic                         slot_vld;
    logic [spot_pkg::RET_W-1:0]   ret_inc;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Slot storage: owner, page and return count
    spot_ram #(
        .WIDTH (spot_pkg::ENT_W),
        .DEPTH (spot_pkg::SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Scan read side
    assign rd_en   = (state_reg == ST_SCAN) && (cnt_reg < spot_pkg::CNT_W'(spot_pkg::SLOTS));
    assign rd_addr = cnt_reg[spot_pkg::IDX_W-1:0];

    assign slot_vld = valid_reg[chk_idx_reg];

    assign scan_ctl.clear = accept;
    assign scan_ctl.live  = live_reg;
    assign scan_ctl.del   = (op_reg == spot_pkg::OP_DELETE);
    assign scan_ctl.idx   = chk_idx_reg;

    spot_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .key_owner (own_reg),
        .key_page  (pg_reg),
        .slot_vld  (slot_vld),
        .entry     (spot_pkg::entry_t'(rd_data)),
        .res       (scan_res),
        .kill      (kill)
    );

    // Saturating increment for a load
    assign ret_inc = (scan_res.hit_ret == spot_pkg::RET_MAX) ?
                     scan_res.hit_ret : scan_res.hit_ret + spot_pkg::RET_W'(1);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        own_next     = own_reg;
        pg_next      = pg_reg;
        cnt_next     = cnt_reg;
        live_next    = rd_en;
        chk_idx_next = rd_addr;
        valid_next   = valid_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = scan_res.hit_idx;
        wr_entry     = '{owner: own_reg, page: pg_reg, returns: ret_inc};

        if (kill) begin
            valid_next[chk_idx_reg] = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = s_data.operation;
                    own_next   = s_data.process_id[spot_pkg::OWN_W-1:0];
                    pg_next    = s_data.page[spot_pkg::PG_W-1:0];
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + spot_pkg::CNT_W'(1);
                if (cnt_reg == spot_pkg::CNT_W'(spot_pkg::SLOTS)) begin
                    cnt_next   = cnt_reg;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                pend_next.found        = scan_res.hit;
                pend_next.return_count = scan_res.hit ? scan_res.hit_ret : '0;
                pend_next.free_slots   = scan_res.free_cnt;
                pend_next.error        = spot_pkg::ERR_NONE;
                case (op_reg)
                    spot_pkg::OP_SAVE: begin
                        if (!scan_res.hit) begin
                            if (scan_res.has_free) begin
                                wr_en        = 1'b1;
                                wr_addr      = scan_res.free_idx;
                                wr_entry     = '{owner: own_reg, page: pg_reg, returns: '0};
                                valid_next[scan_res.free_idx] = 1'b1;
                                pend_next.free_slots =
                                    scan_res.free_cnt - spot_pkg::FREE_W'(1);
                            end else begin
                                pend_next.error = spot_pkg::ERR_FULL;
                            end
                        end
                    end
                    spot_pkg::OP_LOAD: begin
                        if (scan_res.hit) begin
                            wr_en                  = 1'b1;
                            pend_next.return_count = ret_inc;
                        end else begin
                            pend_next.error = spot_pkg::ERR_ABSENT;
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            live_reg    <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            live_reg    <= live_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        own_reg     <= own_next;
        pg_reg      <= pg_next;
        chk_idx_reg <= chk_idx_next;
        pend_reg    <= pend_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request taken while an operation is in flight");

    a_fill_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) && (op_reg == spot_pkg::OP_SAVE) && !scan_res.hit
        && scan_res.has_free |-> !valid_reg[scan_res.free_idx])
        else $error("save would overwrite a live slot");

    a_hit_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) && scan_res.hit |-> valid_reg[scan_res.hit_idx])
        else $error("hit reported on a free slot");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= spot_pkg::CNT_W'(spot_pkg::SLOTS))
        else $error("scan counter ran past the table");

    a_no_read_outside_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg |-> $past(state_reg == ST_SCAN))
        else $error("slot check outside the scan");

endmodule

// File: hw/rtl/spot_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module spot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/spot_scan.sv
// Shared compare unit: checks one slot a cycle against the key and
// accumulates hit, lowest free slot and free count over the scan
module spot_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spot_pkg::scan_ctl_t           ctl,
    input  logic [spot_pkg::OWN_W-1:0]    key_owner,
    input  logic [spot_pkg::PG_W-1:0]     key_page,
    input  logic                          slot_vld,
    input  spot_pkg::entry_t              entry,
    output spot_pkg::scan_res_t           res,
    output logic                          kill
);

    spot_pkg::scan_res_t res_reg, res_next;
    logic                own_eq;
    logic                pair_eq;

    // Key compare
    assign own_eq  = (entry.owner == key_owner);
    assign pair_eq = own_eq && (entry.page == key_page);

    // Delete frees every live slot of the owner
    assign kill = ctl.live && ctl.del && slot_vld && own_eq;

    // Accumulate
    always_comb begin
        res_next = res_reg;
        if (ctl.clear) begin
            res_next = '0;
        end else if (ctl.live) begin
            if (slot_vld && pair_eq && !ctl.del && !res_reg.hit) begin
                res_next.hit     = 1'b1;
                res_next.hit_idx = ctl.idx;
                res_next.hit_ret = entry.returns;
            end
            if (!slot_vld && !res_reg.has_free) begin
                res_next.has_free = 1'b1;
                res_next.free_idx = ctl.idx;
            end
            if (!slot_vld || kill) begin
                res_next.free_cnt = res_reg.free_cnt + spot_pkg::FREE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
